FILE: design/key_debounce_click_hold_defines.svh
// assertion macros shared by the checker
`ifndef KEY_DEBOUNCE_CLICK_HOLD_DEFINES_SVH
`define KEY_DEBOUNCE_CLICK_HOLD_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KDCH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdch check failed");

// next-cycle implication, disabled while in reset
`define KDCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdch check failed");

`endif

FILE: design/kdch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kdch_pkg;

    localparam int CNT_W    = 16;
    localparam int CLICKS_W = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_HOLD = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_RELEASED = 2'd1,
        EV_HOLD     = 2'd2,
        EV_CLICKS   = 2'd3
    } event_t;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_HOLD       = 2'd1;
    localparam logic [1:0] REG_CLICK_GAP  = 2'd2;
    localparam logic [1:0] REG_MAX_CLICKS = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]    debounce_samples;
        logic [CNT_W-1:0]    hold_samples;
        logic [CNT_W-1:0]    click_gap_samples;
        logic [CLICKS_W-1:0] max_clicks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_samples:  16'd3,
        hold_samples:      16'd100,
        click_gap_samples: 16'd30,
        max_clicks:        4'd3
    };

    typedef struct packed {
        mode_t               mode;
        logic [CNT_W-1:0]    press_cnt;
        logic [CNT_W-1:0]    release_cnt;
        logic [CNT_W-1:0]    gap_cnt;
        logic [CLICKS_W-1:0] clicks;
    } key_state_t;

    localparam key_state_t KEY_STATE_RESET = '{
        mode:        MODE_OFF,
        press_cnt:   16'd0,
        release_cnt: 16'd0,
        gap_cnt:     16'd0,
        clicks:      4'd0
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: design/kdch_update.sv
`timescale 1ns / 1ps
`default_nettype none

// next state and event for one key and one sample
module kdch_update (
    input  kdch_pkg::key_state_t              cur,
    input  logic                              pressed,
    input  kdch_pkg::cfg_t                    cfg,
    output kdch_pkg::key_state_t              nxt,
    output kdch_pkg::event_t                  event_code,
    output logic [kdch_pkg::CLICKS_W-1:0]     click_total
);

    logic [kdch_pkg::CNT_W-1:0] press_inc;
    logic [kdch_pkg::CNT_W-1:0] release_inc;
    logic [kdch_pkg::CNT_W-1:0] gap_inc;

    assign press_inc   = kdch_pkg::sat_inc(cur.press_cnt);
    assign release_inc = kdch_pkg::sat_inc(cur.release_cnt);
    assign gap_inc     = kdch_pkg::sat_inc(cur.gap_cnt);

    always_comb
    begin
        nxt         = cur;
        event_code  = kdch_pkg::EV_NONE;
        click_total = '0;
        unique case (cur.mode)
            kdch_pkg::MODE_OFF:
            begin
                if (pressed)
                begin
                    nxt.press_cnt = press_inc;
                    if (press_inc >= cfg.debounce_samples)
                    begin
                        nxt.mode      = kdch_pkg::MODE_ON;
                        nxt.press_cnt = '0;
                        if (cur.clicks == '0)
                        begin
                            nxt.clicks = 4'd1;
                        end
                        else if (cur.clicks < cfg.max_clicks)
                        begin
                            nxt.clicks  = cur.clicks + 1'b1;
                            nxt.gap_cnt = '0;
                        end
                    end
                end
                else
                begin
                    nxt.press_cnt = '0;
                    if (cur.clicks != '0)
                    begin
                        nxt.gap_cnt = gap_inc;
                        // gap compared before it counts
                        if (cur.gap_cnt > cfg.click_gap_samples)
                        begin
                            event_code  = kdch_pkg::EV_CLICKS;
                            click_total = cur.clicks;
                            nxt.gap_cnt = '0;
                            nxt.clicks  = '0;
                        end
                    end
                end
            end
            kdch_pkg::MODE_ON:
            begin
                if (pressed)
                begin
                    nxt.release_cnt = '0;
                    nxt.gap_cnt     = '0;
                    nxt.press_cnt   = press_inc;
                    if (cur.clicks == 4'd1 && press_inc >= cfg.hold_samples)
                    begin
                        nxt.press_cnt = '0;
                        nxt.mode      = kdch_pkg::MODE_HOLD;
                        event_code    = kdch_pkg::EV_HOLD;
                    end
                end
                else
                begin
                    nxt.release_cnt = release_inc;
                    if (release_inc >= cfg.debounce_samples)
                    begin
                        nxt.mode        = kdch_pkg::MODE_OFF;
                        nxt.release_cnt = '0;
                        event_code      = kdch_pkg::EV_RELEASED;
                    end
                end
            end
            default:
            begin
                // hold, and any unused mode code
                if (pressed)
                begin
                    nxt.release_cnt = '0;
                    nxt.gap_cnt     = '0;
                    nxt.clicks      = '0;
                    event_code      = kdch_pkg::EV_HOLD;
                end
                else
                begin
                    nxt.release_cnt = release_inc;
                    if (release_inc >= cfg.debounce_samples)
                    begin
                        nxt.mode        = kdch_pkg::MODE_OFF;
                        nxt.release_cnt = '0;
                        event_code      = kdch_pkg::EV_RELEASED;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/kdch_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

// register file behind the apb port
module kdch_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdch_pkg::ADDR_W-1:0]   paddr,
    input  logic [kdch_pkg::DATA_W-1:0]   pwdata,
    output logic [kdch_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output kdch_pkg::cfg_t                cfg
);

    kdch_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= kdch_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                kdch_pkg::REG_DEBOUNCE:   cfg_reg.debounce_samples  <= pwdata[15:0];
                kdch_pkg::REG_HOLD:       cfg_reg.hold_samples      <= pwdata[15:0];
                kdch_pkg::REG_CLICK_GAP:  cfg_reg.click_gap_samples <= pwdata[15:0];
                kdch_pkg::REG_MAX_CLICKS: cfg_reg.max_clicks        <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            kdch_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce_samples};
            kdch_pkg::REG_HOLD:       prdata = {16'd0, cfg_reg.hold_samples};
            kdch_pkg::REG_CLICK_GAP:  prdata = {16'd0, cfg_reg.click_gap_samples};
            kdch_pkg::REG_MAX_CLICKS: prdata = {28'd0, cfg_reg.max_clicks};
        endcase
    end

endmodule

`default_nettype wire

FILE: design/key_debounce_click_hold.sv
`timescale 1ns / 1ps
`default_nettype none

// key debounce with multi-click counting and long-press detection
// input stream: one beat per scan tick, s_tuser picks the key, s_tdata[0] is
//   the raw pin level (1 pressed); every accepted beat gives exactly one
//   output beat, event none included
// output stream: m_tuser is the event (none, released, hold, click sequence
//   ended), m_tdata[3:0] the click count of an ended sequence, else zero
// apb port: four registers at 0x0, 0x4, 0x8, 0xc (debounce, hold, click gap,
//   max clicks); write only while the stream is idle
// path: from input accept through the input register, then one pass of the
//   per-key update into the result register, which drives m_tvalid
// throughput: one beat per cycle while m_tready is high, same key or not, since
//   the key state is written on the same edge that loads the result register
// reset: all keys off with counters and pending clicks cleared, registers
//   back to their defaults, both pipeline stages empty
// stall: while m_tready is low the result holds; one more beat is taken into
//   the input register, then s_tready drops until the result is taken
// a key index at or above NUM_KEYS leaves all state alone and reports none
module key_debounce_click_hold #(
    parameter int NUM_KEYS = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdch_pkg::ADDR_W-1:0]   paddr,
    input  logic [kdch_pkg::DATA_W-1:0]   pwdata,
    output logic [kdch_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] pin_level, rest zero
    input  logic [0:0]                    s_tuser,   // [0] key_select
    // event stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [3:0] click_total, rest zero
    output logic [1:0]                    m_tuser    // [1:0] event_code
);

    // the key field is one bit wide, so at most two keys are ever addressed
    localparam int KEYS_USED = (NUM_KEYS < 2) ? NUM_KEYS : 2;

    kdch_pkg::cfg_t cfg;

    // input stage
    logic in_valid_reg;
    logic in_key_reg;
    logic in_pin_reg;

    // result stage
    logic                          out_valid_reg;
    kdch_pkg::event_t              out_event_reg;
    logic [kdch_pkg::CLICKS_W-1:0] out_clicks_reg;

    // per-key state
    kdch_pkg::key_state_t key_state_reg [KEYS_USED];
    kdch_pkg::key_state_t cur_state;
    kdch_pkg::key_state_t key_state_next;
    logic                 key_ok;

    kdch_pkg::event_t              upd_event;
    logic [kdch_pkg::CLICKS_W-1:0] upd_clicks;

    logic advance;
    logic s_accept;

    kdch_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held beat moves on whenever the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_key_reg <= s_tuser[0];
            in_pin_reg <= s_tdata[0];
        end
    end

    // pick the addressed key; out-of-range keys see the reset state
    always_comb
    begin
        cur_state = kdch_pkg::KEY_STATE_RESET;
        key_ok    = 1'b0;
        for (int k = 0; k < KEYS_USED; k++)
        begin
            if (in_key_reg == 1'(k))
            begin
                cur_state = key_state_reg[k];
                key_ok    = 1'b1;
            end
        end
    end

    kdch_update u_update (
        .cur         (cur_state),
        .pressed     (in_pin_reg),
        .cfg         (cfg),
        .nxt         (key_state_next),
        .event_code  (upd_event),
        .click_total (upd_clicks)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEYS_USED; k++)
            begin
                key_state_reg[k] <= kdch_pkg::KEY_STATE_RESET;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < KEYS_USED; k++)
            begin
                if (in_key_reg == 1'(k))
                begin
                    key_state_reg[k] <= key_state_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg  <= key_ok ? upd_event : kdch_pkg::EV_NONE;
            out_clicks_reg <= key_ok ? upd_clicks : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {4'd0, out_clicks_reg};

endmodule

`default_nettype wire

FILE: design/kdch_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "key_debounce_click_hold_defines.svh"

module kdch_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // a stalled result beat stays put
    `KDCH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // only a finished click sequence carries a count
    `KDCH_ASSERT_NOW(a_clicks_only_on_end, clk, rst_n, m_tvalid && (m_tuser != kdch_pkg::EV_CLICKS), m_tdata == 8'd0)

    // a finished sequence always has at least one click
    `KDCH_ASSERT_NOW(a_clicks_nonzero, clk, rst_n, m_tvalid && (m_tuser == kdch_pkg::EV_CLICKS), m_tdata[3:0] != 4'd0 && m_tdata[7:4] == 4'd0)

    // with the result slot empty the input side never stalls
    `KDCH_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

endmodule

bind key_debounce_click_hold kdch_checker u_kdch_checker (.*);

`default_nettype wire
